[hdl/bfd_pkg.sv]
package bfd_pkg;

    localparam int FRAME_W = 16;
    localparam int COLOR_W = 16;
    localparam int POS_W   = 8;

    localparam logic [COLOR_W-1:0] FORE_COLOR_RESET = 16'hFFFF;
    localparam logic [COLOR_W-1:0] BACK_COLOR_RESET = 16'h0000;

    localparam logic CFG_FORE_COLOR = 1'b0;
    localparam logic CFG_BACK_COLOR = 1'b1;

    typedef enum logic [2:0] {
        OP_WRITE_PIXEL = 3'd0,
        OP_READ_PIXEL  = 3'd1,
        OP_WRITE_ROW   = 3'd2,
        OP_READ_ROW    = 3'd3,
        OP_REFRESH_ROW = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } scan_ctrl_t;

    typedef struct packed {
        logic hit;
        logic on;
        logic rest_zero;
    } scan_stat_t;

endpackage

[hdl/bfd_ram.sv]
module bfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/bfd_scan.sv]
module bfd_scan import bfd_pkg::*; #(
    parameter int CELL_PITCH = 8
) (
    input  logic               clk,
    input  scan_ctrl_t         ctrl,
    input  logic [FRAME_W-1:0] now_row,
    input  logic [FRAME_W-1:0] diff_row,
    output scan_stat_t         stat,
    output logic [POS_W-1:0]   cell_x
);

    localparam logic [POS_W-1:0] PITCH = POS_W'(CELL_PITCH);

    logic [FRAME_W-1:0] diff_sr_reg;
    logic [FRAME_W-1:0] diff_sr_next;
    logic [FRAME_W-1:0] now_sr_reg;
    logic [FRAME_W-1:0] now_sr_next;
    logic [POS_W-1:0]   x_reg;
    logic [POS_W-1:0]   x_next;

    always_comb
    begin
        diff_sr_next = diff_sr_reg;
        now_sr_next  = now_sr_reg;
        x_next       = x_reg;
        if (ctrl.load)
        begin
            diff_sr_next = diff_row;
            now_sr_next  = now_row;
            x_next       = '0;
        end
        else if (ctrl.step)
        begin
            diff_sr_next = {1'b0, diff_sr_reg[FRAME_W-1:1]};
            now_sr_next  = {1'b0, now_sr_reg[FRAME_W-1:1]};
            x_next       = x_reg + PITCH;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_sr_reg <= diff_sr_next;
        now_sr_reg  <= now_sr_next;
        x_reg       <= x_next;
    end

    assign stat.hit       = diff_sr_reg[0];
    assign stat.on        = now_sr_reg[0];
    assign stat.rest_zero = (diff_sr_reg[FRAME_W-1:1] == '0);
    assign cell_x         = x_reg;

endmodule

[hdl/bitplane_framebuffer_diff_refresh.sv]
// read reply: exec waits for a free output slot, loads the result, then returns idle
// pixel write: updated in exec; row write: at accept; unused codes ignored; no result
// row refresh: exec loads the scan, then one column per cycle up to the highest
// changed one, one draw per changed cell, set by the column shift registers
// reset: per-row valid flags clear so both frames read as zero, colors take reset values
// output stalls hold the column scan; an idle block accepts while a result waits
module bitplane_framebuffer_diff_refresh import bfd_pkg::*; #(
    parameter int ROW_COUNT    = 32,
    parameter int COLUMN_COUNT = 16,
    parameter int CELL_PITCH   = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [2:0]   operation,
    input  logic [5:0]   row_index,
    input  logic [3:0]   column,
    input  logic         pixel_value,
    input  logic [15:0]  row_bits,
    output logic         out_valid,
    input  logic         out_stall,
    output logic         is_draw,
    output logic [15:0]  read_data,
    output logic [7:0]   cell_x,
    output logic [7:0]   cell_y,
    output logic [15:0]  cell_color,
    output logic         last,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int ROW_AW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam logic [6:0] ROW_LIMIT = 7'(ROW_COUNT);
    localparam logic [4:0] COL_LIMIT = 5'(COLUMN_COUNT);
    localparam logic [FRAME_W-1:0] COL_MASK = FRAME_W'((32'd1 << COLUMN_COUNT) - 32'd1);
    localparam logic [POS_W-1:0] PITCH = POS_W'(CELL_PITCH);

    state_t state_reg;
    state_t state_next;

    op_t                op_in;
    op_t                op_reg;
    logic [5:0]         row_reg;
    logic [3:0]         col_reg;
    logic               pix_reg;

    logic [COLOR_W-1:0] fore_color_reg;
    logic [COLOR_W-1:0] back_color_reg;

    logic [ROW_COUNT-1:0] pend_valid_reg;
    logic [ROW_COUNT-1:0] pend_valid_next;
    logic [ROW_COUNT-1:0] drawn_valid_reg;
    logic [ROW_COUNT-1:0] drawn_valid_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               is_draw_reg;
    logic [FRAME_W-1:0] read_data_reg;
    logic [POS_W-1:0]   cell_x_reg;
    logic [POS_W-1:0]   cell_y_reg;
    logic [COLOR_W-1:0] cell_color_reg;
    logic               last_reg;

    logic               is_draw_next;
    logic [FRAME_W-1:0] read_data_next;
    logic [POS_W-1:0]   cell_x_next;
    logic [POS_W-1:0]   cell_y_next;
    logic [COLOR_W-1:0] cell_color_next;
    logic               last_next;
    logic               out_load;

    logic               in_acc;
    logic               slot_free;
    logic               row_ok_in;
    logic               row_ok;
    logic               col_ok;
    logic [ROW_AW-1:0]  row_addr_in;
    logic [ROW_AW-1:0]  row_addr;

    logic               pend_we;
    logic [ROW_AW-1:0]  pend_waddr;
    logic [FRAME_W-1:0] pend_wdata;
    logic               drawn_we;
    logic [FRAME_W-1:0] pend_q;
    logic [FRAME_W-1:0] drawn_q;
    logic [FRAME_W-1:0] pend_row;
    logic [FRAME_W-1:0] drawn_row;
    logic [FRAME_W-1:0] diff_row;
    logic [FRAME_W-1:0] pix_mask;
    logic [POS_W-1:0]   y_pos;

    scan_ctrl_t         scan_ctrl;
    scan_stat_t         scan_stat;
    logic [POS_W-1:0]   scan_x;

    assign op_in       = op_t'(operation);
    assign in_stall    = (state_reg != ST_IDLE);
    assign in_acc      = in_valid && !in_stall;
    assign slot_free   = !out_valid_reg || !out_stall;
    assign cfg_ready   = 1'b1;

    assign row_ok_in   = ({1'b0, row_index} < ROW_LIMIT);
    assign row_ok      = ({1'b0, row_reg} < ROW_LIMIT);
    assign col_ok      = ({1'b0, col_reg} < COL_LIMIT);
    assign row_addr_in = row_index[ROW_AW-1:0];
    assign row_addr    = row_reg[ROW_AW-1:0];

    assign pend_row  = pend_valid_reg[row_addr] ? pend_q : '0;
    assign drawn_row = drawn_valid_reg[row_addr] ? drawn_q : '0;
    assign diff_row  = pend_row ^ drawn_row;
    assign pix_mask  = FRAME_W'(1) << col_reg;
    assign y_pos     = POS_W'({2'b00, row_reg} * PITCH);

    bfd_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (ROW_COUNT)
    ) u_pend_ram (
        .clk     (clk),
        .wr_en   (pend_we),
        .wr_addr (pend_waddr),
        .wr_data (pend_wdata),
        .rd_en   (in_acc),
        .rd_addr (row_addr_in),
        .rd_data (pend_q)
    );

    bfd_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (ROW_COUNT)
    ) u_drawn_ram (
        .clk     (clk),
        .wr_en   (drawn_we),
        .wr_addr (row_addr),
        .wr_data (pend_row),
        .rd_en   (in_acc),
        .rd_addr (row_addr_in),
        .rd_data (drawn_q)
    );

    bfd_scan #(
        .CELL_PITCH (CELL_PITCH)
    ) u_scan (
        .clk      (clk),
        .ctrl     (scan_ctrl),
        .now_row  (pend_row),
        .diff_row (diff_row),
        .stat     (scan_stat),
        .cell_x   (scan_x)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (op_in)
                        OP_WRITE_PIXEL, OP_READ_PIXEL, OP_READ_ROW, OP_REFRESH_ROW:
                            state_next = ST_EXEC;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EXEC:
            begin
                unique case (op_reg)
                    OP_READ_PIXEL, OP_READ_ROW:
                    begin
                        if (slot_free)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    OP_REFRESH_ROW:
                    begin
                        if (row_ok && (diff_row != '0))
                        begin
                            state_next = ST_SCAN;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                        state_next = ST_IDLE;
                endcase
            end
            ST_SCAN:
            begin
                if (scan_ctrl.step && scan_stat.rest_zero)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb
    begin
        pend_we         = 1'b0;
        pend_waddr      = row_addr;
        pend_wdata      = pix_reg ? (pend_row | pix_mask) : (pend_row & ~pix_mask);
        drawn_we        = 1'b0;
        scan_ctrl       = '0;
        out_load        = 1'b0;
        is_draw_next    = 1'b0;
        read_data_next  = '0;
        cell_x_next     = '0;
        cell_y_next     = '0;
        cell_color_next = '0;
        last_next       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (op_in == OP_WRITE_ROW) && row_ok_in)
                begin
                    pend_we    = 1'b1;
                    pend_waddr = row_addr_in;
                    pend_wdata = row_bits & COL_MASK;
                end
            end
            ST_EXEC:
            begin
                unique case (op_reg)
                    OP_WRITE_PIXEL:
                        pend_we = row_ok && col_ok;
                    OP_READ_PIXEL:
                    begin
                        out_load       = slot_free;
                        read_data_next = {{(FRAME_W-1){1'b0}},
                                          row_ok && col_ok && pend_row[col_reg]};
                    end
                    OP_READ_ROW:
                    begin
                        out_load       = slot_free;
                        read_data_next = row_ok ? pend_row : '0;
                    end
                    OP_REFRESH_ROW:
                    begin
                        drawn_we       = row_ok;
                        scan_ctrl.load = row_ok;
                    end
                    default:
                        pend_we = 1'b0;
                endcase
            end
            ST_SCAN:
            begin
                if (scan_stat.hit)
                begin
                    scan_ctrl.step  = slot_free;
                    out_load        = slot_free;
                    is_draw_next    = 1'b1;
                    cell_x_next     = scan_x;
                    cell_y_next     = y_pos;
                    cell_color_next = scan_stat.on ? fore_color_reg : back_color_reg;
                    last_next       = scan_stat.rest_zero;
                end
                else
                begin
                    scan_ctrl.step = 1'b1;
                end
            end
            default:
                pend_we = 1'b0;
        endcase
    end

    always_comb
    begin
        pend_valid_next  = pend_valid_reg;
        drawn_valid_next = drawn_valid_reg;
        if (pend_we)
        begin
            pend_valid_next[pend_waddr] = 1'b1;
        end
        if (drawn_we)
        begin
            drawn_valid_next[row_addr] = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            pend_valid_reg  <= '0;
            drawn_valid_reg <= '0;
            fore_color_reg  <= FORE_COLOR_RESET;
            back_color_reg  <= BACK_COLOR_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            pend_valid_reg  <= pend_valid_next;
            drawn_valid_reg <= drawn_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_FORE_COLOR: fore_color_reg <= cfg_data;
                    CFG_BACK_COLOR: back_color_reg <= cfg_data;
                endcase
            end
        end
    end

    // request capture and result register
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg  <= op_in;
            row_reg <= row_index;
            col_reg <= column;
            pix_reg <= pixel_value;
        end
        if (out_load)
        begin
            is_draw_reg    <= is_draw_next;
            read_data_reg  <= read_data_next;
            cell_x_reg     <= cell_x_next;
            cell_y_reg     <= cell_y_next;
            cell_color_reg <= cell_color_next;
            last_reg       <= last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign is_draw    = is_draw_reg;
    assign read_data  = read_data_reg;
    assign cell_x     = cell_x_reg;
    assign cell_y     = cell_y_reg;
    assign cell_color = cell_color_reg;
    assign last       = last_reg;

endmodule
